@@ rtl/lr_pkg.sv @@
// Shared constants and types for the line rasterizer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package lr_pkg;

  localparam int unsigned CoordBitsDef = 13;
  localparam int unsigned ColorBits    = 24;

  typedef enum logic {
    OpLoad = 1'b0,
    OpStep = 1'b1
  } op_e;

endpackage

@@ rtl/lr_if.sv @@
// Valid/ready channel interfaces for line commands and plotted pixels.
// Depends on lr_pkg.
`timescale 1ns / 1ps

interface lr_cmd_if import lr_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
);
  logic                        valid;
  logic                        ready;
  op_e                         op;
  logic signed [CoordBits-1:0] start_x;
  logic signed [CoordBits-1:0] start_y;
  logic signed [CoordBits-1:0] end_x;
  logic signed [CoordBits-1:0] end_y;
  logic [ColorBits-1:0]        pixel_color;

  modport source (
    output valid, op, start_x, start_y, end_x, end_y, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, op, start_x, start_y, end_x, end_y, pixel_color,
    output ready
  );
endinterface

interface lr_pix_if import lr_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] pix_x;
  logic signed [CoordBits-1:0] pix_y;
  logic [ColorBits-1:0]        pix_color;
  logic                        is_last;

  modport source (
    output valid, pix_x, pix_y, pix_color, is_last,
    input  ready
  );
  modport sink (
    input  valid, pix_x, pix_y, pix_color, is_last,
    output ready
  );
endinterface

@@ rtl/line_rasterizer.sv @@
// Bresenham line rasterizer: one pixel per clock from a loaded line.
// A load command (op = OpLoad) sets up a line and returns nothing; each step
// command (op = OpStep) on an active line returns the current pixel in the
// following cycle, with is_last set on the pixel before the end point (the
// end point itself is never plotted). Steps on an idle line return nothing.
// Commands are taken every clock while the pixel register is empty or being
// drained, so a line of N pixels streams at one pixel per cycle; the single
// error update through lr_step sets that figure.
`timescale 1ns / 1ps

module line_rasterizer import lr_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lr_cmd_if.sink   cmd_i,
  lr_pix_if.source pix_o
);

  localparam int unsigned ErrBits = CoordBits + 3;

  logic signed [CoordBits-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
  logic [CoordBits:0]          delta_x_q, delta_y_q;
  logic                        step_x_neg_q, step_y_neg_q;
  logic signed [ErrBits-1:0]   error_q;
  logic [ColorBits-1:0]        line_color_q;
  logic                        busy_q;

  logic                        out_valid_q;
  logic signed [CoordBits-1:0] out_x_q, out_y_q;
  logic [ColorBits-1:0]        out_color_q;
  logic                        out_last_q;

  logic [CoordBits:0]          ld_dx, ld_dy;
  logic                        ld_x_neg, ld_y_neg, ld_busy;
  logic signed [ErrBits-1:0]   ld_err;

  logic signed [CoordBits-1:0] st_x, st_y;
  logic signed [ErrBits-1:0]   st_err;
  logic                        st_last;

  logic                        cmd_xfer, do_load, do_step;

  lr_setup #(.CoordBits(CoordBits), .ErrBits(ErrBits)) u_setup (
    .start_x_i    (cmd_i.start_x),
    .start_y_i    (cmd_i.start_y),
    .end_x_i      (cmd_i.end_x),
    .end_y_i      (cmd_i.end_y),
    .delta_x_o    (ld_dx),
    .delta_y_o    (ld_dy),
    .step_x_neg_o (ld_x_neg),
    .step_y_neg_o (ld_y_neg),
    .error_o      (ld_err),
    .busy_o       (ld_busy)
  );

  lr_step #(.CoordBits(CoordBits), .ErrBits(ErrBits)) u_step (
    .cur_x_i      (cur_x_q),
    .cur_y_i      (cur_y_q),
    .tgt_x_i      (tgt_x_q),
    .tgt_y_i      (tgt_y_q),
    .delta_x_i    (delta_x_q),
    .delta_y_i    (delta_y_q),
    .step_x_neg_i (step_x_neg_q),
    .step_y_neg_i (step_y_neg_q),
    .error_i      (error_q),
    .nxt_x_o      (st_x),
    .nxt_y_o      (st_y),
    .nxt_error_o  (st_err),
    .last_o       (st_last)
  );

  assign cmd_i.ready = !out_valid_q || pix_o.ready;
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;
  assign do_load     = cmd_xfer && (cmd_i.op == OpLoad);
  assign do_step     = cmd_xfer && (cmd_i.op == OpStep) && busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      tgt_x_q      <= '0;
      tgt_y_q      <= '0;
      delta_x_q    <= '0;
      delta_y_q    <= '0;
      step_x_neg_q <= 1'b0;
      step_y_neg_q <= 1'b0;
      error_q      <= '0;
      line_color_q <= '0;
      busy_q       <= 1'b0;
    end else if (do_load) begin
      cur_x_q      <= cmd_i.start_x;
      cur_y_q      <= cmd_i.start_y;
      tgt_x_q      <= cmd_i.end_x;
      tgt_y_q      <= cmd_i.end_y;
      delta_x_q    <= ld_dx;
      delta_y_q    <= ld_dy;
      step_x_neg_q <= ld_x_neg;
      step_y_neg_q <= ld_y_neg;
      error_q      <= ld_err;
      line_color_q <= cmd_i.pixel_color;
      busy_q       <= ld_busy;
    end else if (do_step) begin
      cur_x_q <= st_x;
      cur_y_q <= st_y;
      error_q <= st_err;
      busy_q  <= !st_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_step) begin
      out_valid_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      out_x_q     <= cur_x_q;
      out_y_q     <= cur_y_q;
      out_color_q <= line_color_q;
      out_last_q  <= st_last;
    end
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.pix_x     = out_x_q;
  assign pix_o.pix_y     = out_y_q;
  assign pix_o.pix_color = out_color_q;
  assign pix_o.is_last   = out_last_q;

endmodule

@@ rtl/lr_setup.sv @@
// Line setup: absolute deltas, step directions and initial error term.
// Depends on lr_pkg; purely combinational.
`timescale 1ns / 1ps

module lr_setup import lr_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef,
  parameter int unsigned ErrBits   = CoordBits + 3
) (
  input  logic signed [CoordBits-1:0] start_x_i,
  input  logic signed [CoordBits-1:0] start_y_i,
  input  logic signed [CoordBits-1:0] end_x_i,
  input  logic signed [CoordBits-1:0] end_y_i,
  output logic [CoordBits:0]          delta_x_o,
  output logic [CoordBits:0]          delta_y_o,
  output logic                        step_x_neg_o,
  output logic                        step_y_neg_o,
  output logic signed [ErrBits-1:0]   error_o,
  output logic                        busy_o
);

  logic signed [CoordBits:0]  sx0, sx1, sy0, sy1;
  logic                       x_lt, y_lt;
  logic signed [ErrBits-1:0]  half_dx, half_dy;

  always_comb begin
    sx0 = {start_x_i[CoordBits-1], start_x_i};
    sx1 = {end_x_i[CoordBits-1], end_x_i};
    sy0 = {start_y_i[CoordBits-1], start_y_i};
    sy1 = {end_y_i[CoordBits-1], end_y_i};
    x_lt = start_x_i < end_x_i;
    y_lt = start_y_i < end_y_i;
    delta_x_o = x_lt ? sx1 - sx0 : sx0 - sx1;
    delta_y_o = y_lt ? sy1 - sy0 : sy0 - sy1;
    step_x_neg_o = !x_lt;
    step_y_neg_o = !y_lt;
    half_dx = {{(ErrBits-CoordBits){1'b0}}, delta_x_o[CoordBits:1]};
    half_dy = {{(ErrBits-CoordBits){1'b0}}, delta_y_o[CoordBits:1]};
    error_o = (delta_x_o > delta_y_o) ? half_dx : -half_dy;
    busy_o = (start_x_i != end_x_i) || (start_y_i != end_y_i);
  end

endmodule

@@ rtl/lr_step.sv @@
// Bresenham step: next position, next error term and end detection.
// Depends on lr_pkg; purely combinational.
`timescale 1ns / 1ps

module lr_step import lr_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef,
  parameter int unsigned ErrBits   = CoordBits + 3
) (
  input  logic signed [CoordBits-1:0] cur_x_i,
  input  logic signed [CoordBits-1:0] cur_y_i,
  input  logic signed [CoordBits-1:0] tgt_x_i,
  input  logic signed [CoordBits-1:0] tgt_y_i,
  input  logic [CoordBits:0]          delta_x_i,
  input  logic [CoordBits:0]          delta_y_i,
  input  logic                        step_x_neg_i,
  input  logic                        step_y_neg_i,
  input  logic signed [ErrBits-1:0]   error_i,
  output logic signed [CoordBits-1:0] nxt_x_o,
  output logic signed [CoordBits-1:0] nxt_y_o,
  output logic signed [ErrBits-1:0]   nxt_error_o,
  output logic                        last_o
);

  localparam logic signed [CoordBits-1:0] One = {{(CoordBits-1){1'b0}}, 1'b1};
  localparam logic signed [ErrBits-1:0]   ErrZero = '0;

  logic signed [ErrBits-1:0] dx_e, dy_e, neg_dx;
  logic                      mv_x, mv_y;

  always_comb begin
    dx_e = {{(ErrBits-CoordBits-1){1'b0}}, delta_x_i};
    dy_e = {{(ErrBits-CoordBits-1){1'b0}}, delta_y_i};
    neg_dx = -dx_e;
    mv_x = error_i > neg_dx;
    mv_y = error_i < dy_e;
    nxt_error_o = error_i - (mv_x ? dy_e : ErrZero) + (mv_y ? dx_e : ErrZero);
    nxt_x_o = mv_x ? (step_x_neg_i ? cur_x_i - One : cur_x_i + One) : cur_x_i;
    nxt_y_o = mv_y ? (step_y_neg_i ? cur_y_i - One : cur_y_i + One) : cur_y_i;
    last_o = (nxt_x_o == tgt_x_i) && (nxt_y_o == tgt_y_i);
  end

endmodule

@@ sim/line_pixel_checker.sv @@
// Checker for the line rasterizer: tracks accepted commands, predicts the pixel stream
// and compares every transfer on the pixel channel with the oldest pending pixel.
// Depends on lr_pkg and the lr_cmd_if / lr_pix_if interfaces.
`timescale 1ns / 1ps

module line_pixel_checker import lr_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  lr_cmd_if    cmd_i,
  lr_pix_if    pix_i,
  output int   mismatches_o,
  output int   pending_o
);

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct {
    coord_t               x;
    coord_t               y;
    logic [ColorBits-1:0] color;
    logic                 last;
  } pixel_t;

  coord_t                      pos_x, pos_y, goal_x, goal_y;
  logic [CoordBits:0]          span_x, span_y;
  logic                        back_x, back_y;
  logic signed [CoordBits+2:0] err;
  logic [ColorBits-1:0]        color_q;
  logic                        active;
  pixel_t                      pixels_due[$];
  pixel_t                      want;
  int                          fails = 0;

  task automatic flag(input string msg);
    fails++;
    if (fails <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic trace_cmd();
    int     sx, sy, ex, ey, dx, dy, e2;
    pixel_t px;
    if (cmd_i.op == OpLoad) begin
      sx = int'(cmd_i.start_x);
      sy = int'(cmd_i.start_y);
      ex = int'(cmd_i.end_x);
      ey = int'(cmd_i.end_y);
      dx = (ex > sx) ? ex - sx : sx - ex;
      dy = (ey > sy) ? ey - sy : sy - ey;
      pos_x   = cmd_i.start_x;
      pos_y   = cmd_i.start_y;
      goal_x  = cmd_i.end_x;
      goal_y  = cmd_i.end_y;
      span_x  = (CoordBits+1)'(dx);
      span_y  = (CoordBits+1)'(dy);
      back_x  = !(sx < ex);
      back_y  = !(sy < ey);
      err     = (CoordBits+3)'((dx > dy) ? dx / 2 : -(dy / 2));
      color_q = cmd_i.pixel_color;
      active  = (sx != ex) || (sy != ey);
    end else if (active) begin
      px.x     = pos_x;
      px.y     = pos_y;
      px.color = color_q;
      e2 = int'(err);
      dx = int'(span_x);
      dy = int'(span_y);
      if (e2 > -dx) begin
        err   = (CoordBits+3)'(int'(err) - dy);
        pos_x = back_x ? coord_t'(pos_x - 1) : coord_t'(pos_x + 1);
      end
      if (e2 < dy) begin
        err   = (CoordBits+3)'(int'(err) + dx);
        pos_y = back_y ? coord_t'(pos_y - 1) : coord_t'(pos_y + 1);
      end
      active  = (pos_x != goal_x) || (pos_y != goal_y);
      px.last = !active;
      pixels_due.push_back(px);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x   = '0;
      pos_y   = '0;
      goal_x  = '0;
      goal_y  = '0;
      span_x  = '0;
      span_y  = '0;
      back_x  = 1'b0;
      back_y  = 1'b0;
      err     = '0;
      color_q = '0;
      active  = 1'b0;
      pixels_due.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cmd_i.valid && cmd_i.ready) trace_cmd();
      if (pix_i.valid && pix_i.ready) begin
        if (pixels_due.size() == 0) begin
          flag($sformatf("unexpected pixel x=%0d y=%0d color=%06h last=%0b",
                         pix_i.pix_x, pix_i.pix_y, pix_i.pix_color, pix_i.is_last));
        end else begin
          want = pixels_due.pop_front();
          if (pix_i.pix_x !== want.x || pix_i.pix_y !== want.y ||
              pix_i.pix_color !== want.color || pix_i.is_last !== want.last) begin
            flag($sformatf({"pixel mismatch: expected x=%0d y=%0d color=%06h last=%0b,",
                            " got x=%0d y=%0d color=%06h last=%0b"},
                           want.x, want.y, want.color, want.last,
                           pix_i.pix_x, pix_i.pix_y, pix_i.pix_color, pix_i.is_last));
          end
        end
      end
      mismatches_o <= fails;
      pending_o    <= pixels_due.size();
    end
  end

endmodule

@@ sim/line_rasterizer_tb.sv @@
// Top of the line rasterizer testbench: clock, reset, command stimulus and pixel-side
// backpressure, with line_pixel_checker beside the block and the final verdict.
// Depends on lr_pkg, lr_cmd_if / lr_pix_if, line_rasterizer and line_pixel_checker.
`timescale 1ns / 1ps

module line_rasterizer_tb;
  import lr_pkg::*;

  localparam int CoordMax    = 2 ** (CoordBitsDef - 1) - 1;
  localparam int CoordMin    = -(2 ** (CoordBitsDef - 1));
  localparam int RandomItems = 1500;
  localparam int CycleLimit  = 200000;

  typedef logic signed [CoordBitsDef-1:0] coord_t;

  logic clk         = 1'b0;
  logic rst_n       = 1'b0;
  logic pix_ready_q = 1'b0;
  logic steady      = 1'b0;
  int   items_sent  = 0;
  int   cycles      = 0;
  int   mismatches;
  int   pending;

  lr_cmd_if cmd ();
  lr_pix_if pix ();

  assign pix.ready = pix_ready_q;

  line_rasterizer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd),
    .pix_o  (pix)
  );

  line_pixel_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd_i        (cmd),
    .pix_i        (pix),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    pix_ready_q <= steady || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t near_coord(input coord_t c, input int reach);
    int off, v;
    off = int'($urandom_range(2 * reach)) - reach;
    v   = int'(c) + off;
    if (v > CoordMax || v < CoordMin) v = int'(c) - off;
    return coord_t'(v);
  endfunction

  task automatic send_cmd(input op_e op, input coord_t sx, sy, ex, ey,
                          input logic [ColorBits-1:0] col);
    if (!steady) begin
      while ($urandom_range(99) < 22) begin
        cmd.valid <= 1'b0;
        @(posedge clk);
      end
    end
    cmd.valid       <= 1'b1;
    cmd.op          <= op;
    cmd.start_x     <= sx;
    cmd.start_y     <= sy;
    cmd.end_x       <= ex;
    cmd.end_y       <= ey;
    cmd.pixel_color <= col;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    items_sent++;
    steady <= (items_sent >= 600 && items_sent < 900);
  endtask

  task automatic draw_line(input coord_t sx, sy, ex, ey,
                           input logic [ColorBits-1:0] col, input int steps);
    send_cmd(OpLoad, sx, sy, ex, ey, col);
    repeat (steps) begin
      send_cmd(OpStep, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
               ColorBits'($urandom));
    end
  endtask

  initial begin
    int     kind, reach, dx, dy, steps, stop_at;
    coord_t sx, sy, ex, ey;
    cmd.valid       <= 1'b0;
    cmd.op          <= OpLoad;
    cmd.start_x     <= '0;
    cmd.start_y     <= '0;
    cmd.end_x       <= '0;
    cmd.end_y       <= '0;
    cmd.pixel_color <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_cmd(OpStep, rand_coord(), rand_coord(), rand_coord(), rand_coord(), 24'h0);
    draw_line(5, -7, 5, -7, 24'h123456, 1);
    draw_line(coord_t'(CoordMin), coord_t'(CoordMin), coord_t'(CoordMax),
              coord_t'(CoordMax), 24'hFFFFFF, 2);
    draw_line(coord_t'(CoordMax), coord_t'(CoordMax), coord_t'(CoordMin),
              coord_t'(CoordMin), 24'h000000, 1);
    draw_line(coord_t'(CoordMin), 0, coord_t'(CoordMax), -3, 24'h5A5A5A, 1);
    draw_line(0, 0, 3, 0, 24'h0000FF, 4);
    draw_line(0, 0, 0, -2, 24'h00FF00, 2);
    draw_line(-1, 2, 1, 7, 24'hFF0000, 2);
    draw_line(10, 10, 7, 9, 24'hA5A5A5, 3);

    stop_at = items_sent + RandomItems;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      sx   = rand_coord();
      sy   = rand_coord();
      if (kind < 70) begin
        reach = ($urandom_range(4) == 0) ? 40 : 8;
        ex = near_coord(sx, reach);
        ey = near_coord(sy, reach);
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        steps = (dx > dy) ? dx : dy;
        if ($urandom_range(9) == 0) steps = $urandom_range(steps);
        else if ($urandom_range(5) == 0) steps++;
        draw_line(sx, sy, ex, ey, ColorBits'($urandom), steps);
      end else if (kind < 80) begin
        draw_line(sx, sy, sx, sy, ColorBits'($urandom), $urandom_range(2));
      end else if (kind < 90) begin
        draw_line(sx, sy, rand_coord(), rand_coord(), ColorBits'($urandom),
                  $urandom_range(40, 1));
      end else begin
        send_cmd(op_e'($urandom_range(1)), sx, sy, rand_coord(), rand_coord(),
                 ColorBits'($urandom));
      end
    end

    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
